### rtl/macroblock_provenance_tracker_macros.svh
// ----------------------------------------------------------------------------
// macroblock provenance tracker assertion macros
// checks compiled in for simulation, empty bodies for synthesis
// ----------------------------------------------------------------------------
`ifndef MACROBLOCK_PROVENANCE_TRACKER_MACROS_SVH
`define MACROBLOCK_PROVENANCE_TRACKER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MPT_ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("mpt assertion failed");

// next-cycle implication
`define MPT_ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("mpt assertion failed");

`else

`define MPT_ASSERT_IMPLY(label, clk, rst, a, b)
`define MPT_ASSERT_NEXT(label, clk, rst, a, b)

`endif

`endif

### rtl/mpt_pkg.sv
// ----------------------------------------------------------------------------
// mpt_pkg
// shared codes, constants, control types and helpers of the tracker
// ----------------------------------------------------------------------------
package mpt_pkg;

  localparam logic [1:0] OP_DECODE = 2'd0;
  localparam logic [1:0] OP_WRITE  = 2'd1;
  localparam logic [1:0] OP_CHECK  = 2'd2;
  localparam logic [1:0] OP_STOP   = 2'd3;

  localparam int CELL_WORDS = 24;
  localparam int CELL_LINES = 16;
  localparam int MB_STRIDE  = 768;
  localparam int LINE_LIMIT = 512;
  localparam int X_LIMIT    = 1024;
  localparam int DIV_STEPS  = 20;

  typedef struct packed {
    logic load;
    logic stop;
    logic dec_span;
    logic dec_update;
    logic div_start;
    logic div_step;
    logic wr_start;
    logic wr_adv;
    logic clr_setup;
    logic walk_step;
    logic walk_init;
    logic ram_we;
    logic ram_tag;
    logic ft_start;
    logic ft_next;
    logic ft_off;
    logic ft_mul;
    logic ft_k;
    logic ft_tag;
    logic ft_miss;
    logic up_setup;
    logic hit;
    logic miss;
    logic finish;
  } mpt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic ring_ready;
    logic w_zero;
    logic rows_zero;
    logic aligned;
    logic loop_ok;
    logic tail;
    logic clr_empty;
    logic cell_in_grid;
    logic div_done;
    logic ft_skip;
    logic ft_match;
    logic ft_last;
    logic up_ok;
    logic up_empty;
    logic tag_bad;
    logic walk_last;
  } mpt_status_t;

  // exact v / 3 for any 24-bit v by reciprocal multiply
  function automatic logic [23:0] div3(input logic [23:0] v);
    logic [47:0] p;
    p = 48'(v) * 48'(24'hAAAAAB);
    return 24'(p >> 25);
  endfunction

endpackage

### rtl/mpt_ram.sv
// ----------------------------------------------------------------------------
// mpt_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module mpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1344
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/mpt_datapath.sv
// ----------------------------------------------------------------------------
// mpt_datapath
// item registers, run table, cell tag memory, divider and result registers
// ----------------------------------------------------------------------------
module mpt_datapath
  import mpt_pkg::*;
#(
  parameter int RING_SLOTS   = 1024,
  parameter int RUN_SLOTS    = 4,
  parameter int GRID_COLUMNS = 42,
  parameter int GRID_LINES   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  mpt_cmd_t    cmd,
  output mpt_status_t status,
  input  logic [1:0]  op,
  input  logic [31:0] source_address,
  input  logic [19:0] word_count,
  input  logic [9:0]  x_pos,
  input  logic [8:0]  y_pos,
  input  logic [10:0] width,
  input  logic [9:0]  height,
  input  logic [8:0]  transfer_line,
  input  logic [19:0] vram_offset,
  output logic [9:0]  ring_slot,
  output logic        hit,
  output logic [10:0] texture_width,
  output logic [9:0]  texture_height,
  output logic [12:0] converter_setup,
  output logic        skip_conversion,
  output logic [31:0] frames_seen,
  output logic [31:0] misses_seen
);

  localparam int ROW_W  = GRID_LINES > 1 ? $clog2(GRID_LINES) : 1;
  localparam int COL_W  = GRID_COLUMNS > 1 ? $clog2(GRID_COLUMNS) : 1;
  localparam int CELLS  = GRID_LINES * GRID_COLUMNS;
  localparam int AW     = CELLS > 1 ? $clog2(CELLS) : 1;
  localparam int RUN_W  = RUN_SLOTS > 1 ? $clog2(RUN_SLOTS) : 1;
  localparam int SLOT_W = $clog2(RING_SLOTS);

  // latched item
  logic [1:0]  item_op;
  logic [31:0] item_addr;
  logic [19:0] item_words;
  logic [9:0]  item_x;
  logic [8:0]  item_y;
  logic [10:0] item_w;
  logic [9:0]  item_h;
  logic [8:0]  item_fl;
  logic [19:0] item_voff;

  // tracker state
  logic              ring_ready;
  logic [31:0]       ring_sequence;
  logic [SLOT_W-1:0] slot_count;
  logic [31:0]       run_base  [RUN_SLOTS];
  logic [31:0]       run_first [RUN_SLOTS];
  logic [31:0]       run_length[RUN_SLOTS];
  logic [RUN_W-1:0]  newest_run;
  logic              skip_flag;
  logic [31:0]       hit_counter;
  logic [31:0]       miss_counter;

  // work registers
  logic [31:0]      dec_span;
  logic [10:0]      div_rem;
  logic [19:0]      div_quo;
  logic [4:0]       div_count;
  logic [9:0]       rows;
  logic [9:0]       row_i;
  logic [9:0]       line;
  logic [31:0]      wr_addr;
  logic [RUN_W-1:0] ft_idx;
  logic [RUN_W-1:0] ft_count;
  logic [31:0]      ft_off;
  logic [23:0]      ft_q;
  logic [31:0]      ft_k;
  logic [31:0]      tag;
  logic             up_ok;
  logic [7:0]       up_cols;
  logic [6:0]       up_rows;
  logic [6:0]       up_c0;
  logic [4:0]       up_r0;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] col;
  logic [COL_W-1:0] col_lo;
  logic [ROW_W-1:0] row_hi;
  logic [COL_W-1:0] col_hi;
  logic [9:0]       res_slot;
  logic             res_hit;
  logic [10:0]      res_tw;
  logic [9:0]       res_th;
  logic [12:0]      res_conv;

  logic [AW-1:0] cell_addr;
  logic [31:0]   ram_rdata;
  logic [31:0]   ram_wdata;

  function automatic logic is_live(input logic [31:0] seq, input logic [31:0] s);
    logic [31:0] d;
    d = seq - s;
    return d <= 32'(RING_SLOTS);
  endfunction

  // write alignment
  logic [23:0] xq24;
  logic [6:0]  xq;
  logic        x_al;
  logic [8:0]  y_diff;
  logic [11:0] x_end;
  logic        aligned;

  assign xq24    = div3(24'(item_x[9:3]));
  assign xq      = xq24[6:0];
  assign x_al    = (item_x[2:0] == 3'd0) && (24'(item_x[9:3]) == (xq24 << 1) + xq24);
  assign y_diff  = item_y - item_fl;
  assign x_end   = 12'(item_x) + 12'(item_w);
  assign aligned = (item_w == 11'(CELL_WORDS)) && x_al && (y_diff[3:0] == 4'd0) &&
                   (item_y[3:0] == 4'd0) && (x_end <= 12'(X_LIMIT));

  // clear rectangle bounds, clamped to the grid
  logic [9:0]  clr_y;
  logic [9:0]  clr_h;
  logic [11:0] c_last;
  logic [23:0] c1q24;
  logic [6:0]  c1;
  logic [6:0]  c1c;
  logic [5:0]  r0;
  logic [10:0] r_last;
  logic [6:0]  r1;
  logic [6:0]  r1c;

  assign clr_y  = aligned ? line : 10'(item_y);
  assign clr_h  = aligned ? rows - row_i : rows;
  assign c_last = x_end - 12'd1;
  assign c1q24  = div3(24'(c_last[11:3]));
  assign c1     = c1q24[6:0];
  assign c1c    = (c1 >= 7'(GRID_COLUMNS)) ? 7'(GRID_COLUMNS - 1) : c1;
  assign r0     = clr_y[9:4];
  assign r_last = 11'(clr_y) + 11'(clr_h) - 11'd1;
  assign r1     = r_last[10:4];
  assign r1c    = (r1 >= 7'(GRID_LINES)) ? 7'(GRID_LINES - 1) : r1;

  // run table read port
  logic [31:0] sel_base, sel_first, sel_len;
  logic [31:0] new_base, new_len;
  logic [RUN_W-1:0] n_next;
  logic        extend;

  assign sel_base  = run_base[ft_idx];
  assign sel_first = run_first[ft_idx];
  assign sel_len   = run_length[ft_idx];
  assign new_base  = run_base[newest_run];
  assign new_len   = run_length[newest_run];
  assign extend    = (new_len != 32'd0) && (item_addr == new_base + dec_span);
  assign n_next    = (newest_run == RUN_W'(RUN_SLOTS - 1)) ? '0 : newest_run + 1'b1;

  // upload geometry
  logic [9:0]  sx;
  logic [8:0]  sy;
  logic [23:0] sxq24;
  logic        sx_al;
  logic [11:0] cols_sum;
  logic [10:0] rows_sum;
  logic [7:0]  cols_n;
  logic [6:0]  rows_n;
  logic [7:0]  up_col_end;
  logic [6:0]  up_row_end;
  logic [6:0]  rows_m1;

  assign sx         = item_voff[10:1];
  assign sy         = item_voff[19:11];
  assign sxq24      = div3(24'(sx[9:3]));
  assign sx_al      = (sx[2:0] == 3'd0) && (24'(sx[9:3]) == (sxq24 << 1) + sxq24);
  assign cols_sum   = 12'(item_w) + 12'd15;
  assign rows_sum   = 11'(item_h) + 11'd15;
  assign cols_n     = cols_sum[11:4];
  assign rows_n     = rows_sum[10:4];
  assign up_col_end = 8'(up_c0) + up_cols - 8'd1;
  assign up_row_end = 7'(up_r0) + up_rows - 7'd1;
  assign rows_m1    = up_rows - 7'd1;

  // divider step
  logic [11:0] div_trial;
  logic        div_fit;

  assign div_trial = {div_rem, div_quo[19]};
  assign div_fit   = div_trial >= 12'(item_w);

  assign cell_addr = AW'(row) * AW'(GRID_COLUMNS) + AW'(col);
  assign ram_wdata = cmd.ram_tag ? tag : 32'd0;

  mpt_ram #(
    .WIDTH(32),
    .DEPTH(CELLS)
  ) u_tag_ram (
    .clk  (clk),
    .we   (cmd.ram_we),
    .waddr(cell_addr),
    .wdata(ram_wdata),
    .raddr(cell_addr),
    .rdata(ram_rdata)
  );

  always_comb begin
    status.op           = item_op;
    status.ring_ready   = ring_ready;
    status.w_zero       = item_w == 11'd0;
    status.rows_zero    = (div_quo == 20'd0) || (item_h == 10'd0);
    status.aligned      = aligned;
    status.loop_ok      = (11'(row_i) + 11'(CELL_LINES) <= 11'(rows)) &&
                          (11'(line) + 11'(CELL_LINES) <= 11'(LINE_LIMIT));
    status.tail         = row_i < rows;
    status.clr_empty    = (xq > c1c) || (7'(r0) > r1c);
    status.cell_in_grid = (7'(line[9:4]) < 7'(GRID_LINES)) && (xq < 7'(GRID_COLUMNS));
    status.div_done     = div_count == 5'(DIV_STEPS - 1);
    status.ft_skip      = (sel_len == 32'd0) || (wr_addr < sel_base);
    status.ft_match     = (ft_off[7:0] == 8'd0) && (ft_off[31:8] == (ft_q << 1) + ft_q) &&
                          (32'(ft_q) < sel_len);
    status.ft_last      = ft_count == RUN_W'(RUN_SLOTS - 1);
    status.up_ok        = up_ok;
    status.up_empty     = (up_cols == 8'd0) || (up_rows == 7'd0);
    status.tag_bad      = (ram_rdata == 32'd0) || !is_live(ring_sequence, ram_rdata - 32'd1);
    status.walk_last    = (row == row_hi) && (col == col_hi);
  end

  // tracker state, reset cleared
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_ready    <= 1'b0;
      ring_sequence <= '0;
      slot_count    <= '0;
      newest_run    <= '0;
      skip_flag     <= 1'b0;
      hit_counter   <= '0;
      miss_counter  <= '0;
      for (int k = 0; k < RUN_SLOTS; k++) begin
        run_base[k]   <= '0;
        run_first[k]  <= '0;
        run_length[k] <= '0;
      end
    end else begin
      if (cmd.dec_update) begin
        ring_ready    <= 1'b1;
        ring_sequence <= ring_sequence + 32'd1;
        slot_count    <= (slot_count == SLOT_W'(RING_SLOTS - 1)) ? '0 : slot_count + 1'b1;
        if (extend) begin
          run_length[newest_run] <= new_len + 32'd1;
        end else begin
          newest_run         <= n_next;
          run_base[n_next]   <= item_addr;
          run_first[n_next]  <= ring_sequence;
          run_length[n_next] <= 32'd1;
        end
      end
      if (cmd.stop) begin
        skip_flag <= 1'b0;
      end
      if (cmd.hit) begin
        skip_flag   <= 1'b1;
        hit_counter <= hit_counter + 32'd1;
      end
      if (cmd.miss) begin
        skip_flag    <= 1'b0;
        miss_counter <= miss_counter + 32'd1;
      end
    end
  end

  // cell walk registers, reset to sweep the whole grid
  always_ff @(posedge clk) begin
    if (rst) begin
      row    <= '0;
      col    <= '0;
      col_lo <= '0;
      row_hi <= ROW_W'(GRID_LINES - 1);
      col_hi <= COL_W'(GRID_COLUMNS - 1);
    end else if (cmd.clr_setup) begin
      row    <= ROW_W'(r0);
      col    <= COL_W'(xq);
      col_lo <= COL_W'(xq);
      row_hi <= ROW_W'(r1c);
      col_hi <= COL_W'(c1c);
    end else if (cmd.walk_init) begin
      row    <= ROW_W'(up_r0);
      col    <= COL_W'(up_c0);
      col_lo <= COL_W'(up_c0);
      row_hi <= ROW_W'(up_row_end);
      col_hi <= COL_W'(up_col_end);
    end else if (cmd.ft_start) begin
      row <= ROW_W'(line[9:4]);
      col <= COL_W'(xq);
    end else if (cmd.walk_step) begin
      if (col == col_hi) begin
        col <= col_lo;
        row <= row + 1'b1;
      end else begin
        col <= col + 1'b1;
      end
    end
  end

  // item and work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_op    <= op;
      item_addr  <= source_address;
      item_words <= word_count;
      item_x     <= x_pos;
      item_y     <= y_pos;
      item_w     <= width;
      item_h     <= height;
      item_fl    <= transfer_line;
      item_voff  <= vram_offset;
      wr_addr    <= source_address;
      res_slot   <= '0;
      res_hit    <= 1'b0;
      res_tw     <= '0;
      res_th     <= '0;
      res_conv   <= '0;
    end
    if (cmd.dec_span) begin
      dec_span <= {new_len[22:0], 9'd0} + {new_len[23:0], 8'd0};
    end
    if (cmd.dec_update) begin
      res_slot <= 10'(slot_count);
    end
    if (cmd.div_start) begin
      div_rem   <= '0;
      div_quo   <= item_words;
      div_count <= '0;
    end else if (cmd.div_step) begin
      div_rem   <= div_fit ? 11'(div_trial - 12'(item_w)) : div_trial[10:0];
      div_quo   <= {div_quo[18:0], div_fit};
      div_count <= div_count + 5'd1;
    end
    if (cmd.wr_start) begin
      rows  <= (div_quo < 20'(item_h)) ? div_quo[9:0] : item_h;
      row_i <= '0;
      line  <= 10'(item_y);
    end else if (cmd.wr_adv) begin
      row_i   <= row_i + 10'(CELL_LINES);
      line    <= line + 10'(CELL_LINES);
      wr_addr <= wr_addr + 32'(MB_STRIDE);
    end
    if (cmd.ft_start) begin
      ft_idx   <= newest_run;
      ft_count <= '0;
    end else if (cmd.ft_next) begin
      ft_idx   <= (ft_idx == '0) ? RUN_W'(RUN_SLOTS - 1) : ft_idx - 1'b1;
      ft_count <= ft_count + 1'b1;
    end
    if (cmd.ft_off) begin
      ft_off <= wr_addr - sel_base;
    end
    if (cmd.ft_mul) begin
      ft_q <= div3(ft_off[31:8]);
    end
    if (cmd.ft_k) begin
      ft_k <= sel_first + 32'(ft_q);
    end
    if (cmd.ft_tag) begin
      tag <= is_live(ring_sequence, ft_k) ? ft_k + 32'd1 : 32'd0;
    end else if (cmd.ft_miss) begin
      tag <= 32'd0;
    end
    if (cmd.up_setup) begin
      up_ok   <= ring_ready && !item_voff[0] && sx_al && (sy[3:0] == 4'd0) &&
                 (8'(sxq24[6:0]) + cols_n <= 8'(GRID_COLUMNS)) &&
                 (7'(sy[8:4]) + rows_n <= 7'(GRID_LINES));
      up_cols <= cols_n;
      up_rows <= rows_n;
      up_c0   <= sxq24[6:0];
      up_r0   <= sy[8:4];
    end
    if (cmd.hit) begin
      res_hit  <= 1'b1;
      res_tw   <= (up_cols <= 8'd32) ? 11'd512 : 11'd1024;
      res_th   <= (up_rows <= 7'd16) ? 10'd256 : 10'd512;
      res_conv <= {rows_m1[4:0], (up_cols <= 8'd32) ? 8'd31 : 8'd63};
    end
    if (cmd.finish) begin
      ring_slot       <= res_slot;
      hit             <= res_hit;
      texture_width   <= res_tw;
      texture_height  <= res_th;
      converter_setup <= res_conv;
      skip_conversion <= skip_flag;
      frames_seen     <= hit_counter;
      misses_seen     <= miss_counter;
    end
  end

endmodule

### rtl/mpt_controller.sv
// ----------------------------------------------------------------------------
// mpt_controller
// sequencer for decode, video write, upload check and stop transactions
// ----------------------------------------------------------------------------
module mpt_controller
  import mpt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  mpt_status_t status,
  output mpt_cmd_t    cmd
);

  typedef enum logic [18:0] {
    S_CLEAR  = 19'h00001,
    S_IDLE   = 19'h00002,
    S_OP     = 19'h00004,
    S_DEC    = 19'h00008,
    S_DIV    = 19'h00010,
    S_WSET   = 19'h00020,
    S_WLOOP  = 19'h00040,
    S_FT_OFF = 19'h00080,
    S_FT_MUL = 19'h00100,
    S_FT_CHK = 19'h00200,
    S_FT_TAG = 19'h00400,
    S_CELL   = 19'h00800,
    S_CSET   = 19'h01000,
    S_CWALK  = 19'h02000,
    S_UP     = 19'h04000,
    S_UPCHK  = 19'h08000,
    S_URD    = 19'h10000,
    S_UCHK   = 19'h20000,
    S_DONE   = 19'h40000
  } state_t;

  state_t state, state_next;

  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_CLEAR: begin
        cmd.ram_we    = 1'b1;
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_OP;
        end
      end
      S_OP: begin
        case (status.op)
          OP_DECODE: begin
            cmd.dec_span = 1'b1;
            state_next   = S_DEC;
          end
          OP_WRITE: begin
            if (!status.ring_ready || status.w_zero) begin
              state_next = S_DONE;
            end else begin
              cmd.div_start = 1'b1;
              state_next    = S_DIV;
            end
          end
          OP_CHECK: begin
            cmd.up_setup = 1'b1;
            state_next   = S_UP;
          end
          default: begin
            cmd.stop   = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_DEC: begin
        cmd.dec_update = 1'b1;
        state_next     = S_DONE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_WSET;
        end
      end
      S_WSET: begin
        cmd.wr_start = 1'b1;
        if (status.rows_zero) begin
          state_next = S_DONE;
        end else if (status.aligned) begin
          state_next = S_WLOOP;
        end else begin
          state_next = S_CSET;
        end
      end
      S_WLOOP: begin
        if (status.loop_ok) begin
          cmd.ft_start = 1'b1;
          state_next   = S_FT_OFF;
        end else if (status.tail) begin
          state_next = S_CSET;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FT_OFF: begin
        if (!status.ft_skip) begin
          cmd.ft_off = 1'b1;
          state_next = S_FT_MUL;
        end else if (status.ft_last) begin
          cmd.ft_miss = 1'b1;
          state_next  = S_CELL;
        end else begin
          cmd.ft_next = 1'b1;
        end
      end
      S_FT_MUL: begin
        cmd.ft_mul = 1'b1;
        state_next = S_FT_CHK;
      end
      S_FT_CHK: begin
        if (status.ft_match) begin
          cmd.ft_k   = 1'b1;
          state_next = S_FT_TAG;
        end else if (status.ft_last) begin
          cmd.ft_miss = 1'b1;
          state_next  = S_CELL;
        end else begin
          cmd.ft_next = 1'b1;
          state_next  = S_FT_OFF;
        end
      end
      S_FT_TAG: begin
        cmd.ft_tag = 1'b1;
        state_next = S_CELL;
      end
      S_CELL: begin
        cmd.ram_we  = status.cell_in_grid;
        cmd.ram_tag = 1'b1;
        cmd.wr_adv  = 1'b1;
        state_next  = S_WLOOP;
      end
      S_CSET: begin
        cmd.clr_setup = 1'b1;
        state_next    = status.clr_empty ? S_DONE : S_CWALK;
      end
      S_CWALK: begin
        cmd.ram_we    = 1'b1;
        cmd.walk_step = 1'b1;
        if (status.walk_last) begin
          state_next = S_DONE;
        end
      end
      S_UP: begin
        state_next = S_UPCHK;
      end
      S_UPCHK: begin
        if (!status.up_ok) begin
          cmd.miss   = 1'b1;
          state_next = S_DONE;
        end else if (status.up_empty) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.walk_init = 1'b1;
          state_next    = S_URD;
        end
      end
      S_URD: begin
        state_next = S_UCHK;
      end
      S_UCHK: begin
        if (status.tag_bad) begin
          cmd.miss   = 1'b1;
          state_next = S_DONE;
        end else if (status.walk_last) begin
          cmd.hit    = 1'b1;
          state_next = S_DONE;
        end else begin
          cmd.walk_step = 1'b1;
          state_next    = S_URD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/macroblock_provenance_tracker.sv
// ----------------------------------------------------------------------------
// macroblock_provenance_tracker
// Follows decoded macroblocks from guest memory into video memory tiles and
// reports whether a frame upload consists only of live decoded cells. One
// transaction is handled at a time and always yields one result. A video
// write runs the 20-step word_count / width divider, then does a run
// lookup and tag write per 16-line band, newest run first, plus a setup
// step and a clear of each cleared cell. An upload check does one tag
// memory read per covered cell. After reset all GRID_LINES * GRID_COLUMNS
// cells (1344 by default) of the tag memory are cleared before in_ready
// rises. A finished result sits in the output register while the next
// transaction is accepted.
// ----------------------------------------------------------------------------
`include "macroblock_provenance_tracker_macros.svh"

module macroblock_provenance_tracker
  import mpt_pkg::*;
#(
  parameter int RING_SLOTS   = 1024,
  parameter int RUN_SLOTS    = 4,
  parameter int GRID_COLUMNS = 42,
  parameter int GRID_LINES   = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  op,
  input  logic [31:0] source_address,
  input  logic [19:0] word_count,
  input  logic [9:0]  x_pos,
  input  logic [8:0]  y_pos,
  input  logic [10:0] width,
  input  logic [9:0]  height,
  input  logic [8:0]  transfer_line,
  input  logic [19:0] vram_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  ring_slot,
  output logic        hit,
  output logic [10:0] texture_width,
  output logic [9:0]  texture_height,
  output logic [12:0] converter_setup,
  output logic        skip_conversion,
  output logic [31:0] frames_seen,
  output logic [31:0] misses_seen
);

  mpt_cmd_t    cmd;
  mpt_status_t status;

  mpt_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .cmd      (cmd)
  );

  mpt_datapath #(
    .RING_SLOTS  (RING_SLOTS),
    .RUN_SLOTS   (RUN_SLOTS),
    .GRID_COLUMNS(GRID_COLUMNS),
    .GRID_LINES  (GRID_LINES)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .op             (op),
    .source_address (source_address),
    .word_count     (word_count),
    .x_pos          (x_pos),
    .y_pos          (y_pos),
    .width          (width),
    .height         (height),
    .transfer_line  (transfer_line),
    .vram_offset    (vram_offset),
    .ring_slot      (ring_slot),
    .hit            (hit),
    .texture_width  (texture_width),
    .texture_height (texture_height),
    .converter_setup(converter_setup),
    .skip_conversion(skip_conversion),
    .frames_seen    (frames_seen),
    .misses_seen    (misses_seen)
  );

  // no tag memory write while waiting for a transaction
  `MPT_ASSERT_IMPLY(a_idle_no_write, clk, rst, in_ready, !cmd.ram_we)
  // a hit result always leaves the skip flag set
  `MPT_ASSERT_IMPLY(a_hit_sets_skip, clk, rst, out_valid && hit, skip_conversion)
  // an accepted transaction is worked on before the next one is taken
  `MPT_ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  // hit and miss are never both counted for one check
  `MPT_ASSERT_IMPLY(a_hit_miss_excl, clk, rst, cmd.hit, !cmd.miss)

endmodule

### sim/macroblock_provenance_tracker_tb.sv
// ----------------------------------------------------------------------------
// macroblock_provenance_tracker_tb
// Drives decodes, video memory writes, upload checks and stops into the
// tracker under random idling and backpressure. A local copy of the tracker
// state predicts each result, and the checker compares every field of each
// result in order.
// ----------------------------------------------------------------------------
module macroblock_provenance_tracker_tb;
  import mpt_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 4000000;
  localparam int RING_DEPTH  = 1024;
  localparam int RUNS        = 4;
  localparam int COLS        = 42;
  localparam int LINES       = 32;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [19:0] words;
    logic [9:0]  x;
    logic [8:0]  y;
    logic [10:0] w;
    logic [9:0]  h;
    logic [8:0]  fl;
    logic [19:0] off;
  } tracker_item_t;

  typedef struct {
    logic [9:0]  slot;
    logic        hit;
    logic [10:0] tex_w;
    logic [9:0]  tex_h;
    logic [12:0] conv;
    logic        skip;
    logic [31:0] frames;
    logic [31:0] misses;
  } tracker_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  op = OP_STOP;
  logic [31:0] source_address = '0;
  logic [19:0] word_count = '0;
  logic [9:0]  x_pos = '0;
  logic [8:0]  y_pos = '0;
  logic [10:0] width = 11'd1;
  logic [9:0]  height = '0;
  logic [8:0]  transfer_line = '0;
  logic [19:0] vram_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  ring_slot;
  logic        hit;
  logic [10:0] texture_width;
  logic [9:0]  texture_height;
  logic [12:0] converter_setup;
  logic        skip_conversion;
  logic [31:0] frames_seen;
  logic [31:0] misses_seen;

  macroblock_provenance_tracker dut (.*);

  always #6 clk = ~clk;

  // tracker state as predicted
  int unsigned mdl_ready, mdl_seq, mdl_newest;
  int unsigned mdl_base [RUNS];
  int unsigned mdl_first[RUNS];
  int unsigned mdl_len  [RUNS];
  int unsigned mdl_tag  [LINES][COLS];
  int unsigned mdl_skip, mdl_hits, mdl_misses;

  tracker_result_t pending_results[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  hits_seen = 0;
  int  cycles = 0;
  bit  idle_on = 1'b1;
  bit  long_hold = 1'b0;

  function automatic bit seq_live(int unsigned s);
    return (mdl_seq - s) <= RING_DEPTH;
  endfunction

  function automatic int unsigned lookup_tag(int unsigned a);
    int unsigned r, ofs, k;
    for (int i = 0; i < RUNS; i++) begin
      r = (mdl_newest + RUNS - i) % RUNS;
      if (mdl_len[r] == 0 || a < mdl_base[r]) continue;
      ofs = a - mdl_base[r];
      if (ofs % MB_STRIDE != 0 || ofs / MB_STRIDE >= mdl_len[r]) continue;
      k = mdl_first[r] + ofs / MB_STRIDE;
      if (!seq_live(k)) return 0;
      return k + 1;
    end
    return 0;
  endfunction

  function automatic void clear_cells(int unsigned x, y, w, h);
    int unsigned c0, c1, r0, r1;
    c0 = x / CELL_WORDS;
    c1 = (x + w - 1) / CELL_WORDS;
    r0 = y / CELL_LINES;
    r1 = (y + h - 1) / CELL_LINES;
    if (c1 >= COLS) c1 = COLS - 1;
    if (r1 >= LINES) r1 = LINES - 1;
    for (int unsigned r = r0; r <= r1; r++)
      for (int unsigned c = c0; c <= c1; c++)
        mdl_tag[r][c] = 0;
  endfunction

  function automatic void predict_write(tracker_item_t it);
    int unsigned a, x, y, w, h, fl, rows, i, line, t;
    a = it.addr; x = it.x; y = it.y; w = it.w; h = it.h; fl = it.fl;
    if (mdl_ready == 0 || w == 0) return;
    rows = it.words / w;
    if (rows > h) rows = h;
    if (rows == 0) return;
    if (w != CELL_WORDS || x % CELL_WORDS != 0 || ((y - fl) & 15) != 0 ||
        y % CELL_LINES != 0 || x + w > X_LIMIT) begin
      clear_cells(x, y, w, rows);
      return;
    end
    i = 0;
    line = y;
    while (i + CELL_LINES <= rows && line + CELL_LINES <= LINE_LIMIT) begin
      t = lookup_tag(a);
      if (line / CELL_LINES < LINES && x / CELL_WORDS < COLS)
        mdl_tag[line / CELL_LINES][x / CELL_WORDS] = t;
      i += CELL_LINES;
      line += CELL_LINES;
      a += MB_STRIDE;
    end
    if (i < rows) clear_cells(x, line, w, rows - i);
  endfunction

  function automatic void predict_check(tracker_item_t it, ref tracker_result_t res);
    int unsigned sx, sy, cols, rows, t, tw, th, cv;
    bit ok;
    ok = (mdl_ready != 0) && !it.off[0];
    sx = (it.off / 2) % 1024;
    sy = (it.off / 2) / 1024;
    cols = (int'(it.w) + 15) / 16;
    rows = (int'(it.h) + 15) / 16;
    if (sx % CELL_WORDS != 0 || sy % CELL_LINES != 0 ||
        sx / CELL_WORDS + cols > COLS || sy / CELL_LINES + rows > LINES)
      ok = 0;
    if (ok) begin
      sx /= CELL_WORDS;
      sy /= CELL_LINES;
      for (int unsigned r = 0; r < rows; r++)
        for (int unsigned c = 0; c < cols; c++) begin
          t = mdl_tag[sy + r][sx + c];
          if (t == 0 || !seq_live(t - 1)) ok = 0;
        end
    end
    if (!ok) begin
      mdl_skip = 0;
      mdl_misses++;
      return;
    end
    tw = cols * 16 <= 512 ? 512 : 1024;
    th = rows * 16 <= 256 ? 256 : 512;
    cv = ((rows - 1) << 8) | (tw / 16 - 1);
    res.hit = 1'b1;
    res.tex_w = 11'(tw);
    res.tex_h = 10'(th);
    res.conv = 13'(cv);
    mdl_skip = 1;
    mdl_hits++;
  endfunction

  function automatic tracker_result_t predict_result(tracker_item_t it);
    tracker_result_t res;
    int unsigned n;
    res = '{default: '0};
    case (it.op)
      OP_DECODE: begin
        n = mdl_newest % RUNS;
        mdl_ready = 1;
        if (mdl_len[n] != 0 && it.addr == mdl_base[n] + mdl_len[n] * MB_STRIDE) begin
          mdl_len[n]++;
        end else begin
          n = (n + 1) % RUNS;
          mdl_newest = n;
          mdl_base[n] = it.addr;
          mdl_first[n] = mdl_seq;
          mdl_len[n] = 1;
        end
        res.slot = 10'(mdl_seq % RING_DEPTH);
        mdl_seq++;
      end
      OP_WRITE: predict_write(it);
      OP_CHECK: predict_check(it, res);
      default: mdl_skip = 0;
    endcase
    res.skip = mdl_skip[0];
    res.frames = mdl_hits;
    res.misses = mdl_misses;
    return res;
  endfunction

  function automatic void reset_model();
    mdl_ready = 0; mdl_seq = 0; mdl_newest = 0;
    mdl_skip = 0; mdl_hits = 0; mdl_misses = 0;
    for (int i = 0; i < RUNS; i++) begin
      mdl_base[i] = 0; mdl_first[i] = 0; mdl_len[i] = 0;
    end
    for (int r = 0; r < LINES; r++)
      for (int c = 0; c < COLS; c++)
        mdl_tag[r][c] = 0;
  endfunction

  // send one transaction; entered and left right after a rising edge
  task automatic send_item(tracker_item_t it);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= it.op;
    source_address <= it.addr;
    word_count <= it.words;
    x_pos <= it.x;
    y_pos <= it.y;
    width <= it.w;
    height <= it.h;
    transfer_line <= it.fl;
    vram_offset <= it.off;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(predict_result(it));
    items_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic tracker_item_t blank_item(logic [1:0] o);
    tracker_item_t it;
    it = '{op: o, w: 11'd1, default: '0};
    return it;
  endfunction

  function automatic tracker_item_t decode_item(logic [31:0] a);
    tracker_item_t it;
    it = blank_item(OP_DECODE);
    it.addr = a;
    return it;
  endfunction

  function automatic tracker_item_t write_item(logic [31:0] a, int x, int y, int w, int h,
                                               int words, int fl);
    tracker_item_t it;
    it = blank_item(OP_WRITE);
    it.addr = a; it.x = 10'(x); it.y = 9'(y); it.w = 11'(w); it.h = 10'(h);
    it.words = 20'(words); it.fl = 9'(fl);
    return it;
  endfunction

  function automatic tracker_item_t check_item(int off, int w, int h);
    tracker_item_t it;
    it = blank_item(OP_CHECK);
    it.off = 20'(off); it.w = 11'(w); it.h = 10'(h);
    return it;
  endfunction

  function automatic tracker_item_t noise_item();
    tracker_item_t it;
    it.op = 2'($urandom);
    it.addr = $urandom;
    it.words = ($urandom_range(0, 15) == 0) ? 20'd524288 : 20'($urandom_range(0, 524287));
    it.x = 10'($urandom);
    it.y = 9'($urandom);
    it.w = 11'($urandom_range(1, 1024));
    it.h = 10'($urandom_range(0, 512));
    it.fl = 9'($urandom);
    it.off = 20'($urandom);
    return it;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t mismatch %s expected %0h actual %0h", $realtime, name, exp_v, act_v);
    end
  endtask

  // result checker
  always @(posedge clk) begin
    tracker_result_t e;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result, nothing pending", $realtime);
      end else begin
        e = pending_results.pop_front();
        check_field("ring_slot", e.slot, ring_slot);
        check_field("hit", e.hit, hit);
        check_field("texture_width", e.tex_w, texture_width);
        check_field("texture_height", e.tex_h, texture_height);
        check_field("converter_setup", e.conv, converter_setup);
        check_field("skip_conversion", e.skip, skip_conversion);
        check_field("frames_seen", e.frames, frames_seen);
        check_field("misses_seen", e.misses, misses_seen);
        if (e.hit) hits_seen++;
      end
    end
  end

  // receiver side: random bursts of ready and not ready, plus one long hold
  initial begin
    int n;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end else begin
        n = $urandom_range(1, 16);
        out_ready <= !(idle_on && $urandom_range(0, 2) == 0);
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_before_ring_ready();
    send_item(write_item(32'h0, 0, 0, 24, 16, 384, 0));
    send_item(check_item(0, 0, 0));
    send_item(blank_item(OP_STOP));
  endtask

  task automatic test_decode_runs();
    send_item(decode_item(32'hFFFF_FD00));
    send_item(decode_item(32'h0000_0000));   // run end wraps past 2^32
    send_item(decode_item(32'hFFFF_FFFF));
    send_item(decode_item(32'h1234_0000));
    send_item(decode_item(32'h5555_AAAA));
    send_item(decode_item(32'h5555_AAAA + MB_STRIDE));
  endtask

  task automatic test_tag_and_hit();
    send_item(decode_item(32'h0010_0000));
    send_item(decode_item(32'h0010_0300));
    send_item(write_item(32'h0010_0000, 0, 0, 24, 32, 768, 0));
    send_item(check_item(0, 16, 32));
    send_item(check_item(0, 0, 0));           // empty frame counts as hit
    send_item(check_item(1, 16, 16));         // odd offset
    send_item(blank_item(OP_STOP));
    send_item(write_item(32'h0010_0000, 0, 0, 24, 16, 384, 5));  // line phase off
    send_item(check_item(0, 16, 32));
  endtask

  task automatic test_field_extremes();
    send_item(write_item(32'hFFFF_FFFF, 1023, 511, 1024, 512, 524288, 511));
    send_item(write_item(32'h0, 0, 0, 1024, 512, 0, 0));    // zero rows
    send_item(write_item(32'h0, 0, 496, 24, 512, 524288, 0)); // bottom band
    send_item(check_item(20'hFFFFF, 2047, 1023));
    send_item(check_item(0, 1024, 512));
    send_item(check_item(20'h00030, 16, 16));  // origin on cell column 1
  endtask

  task automatic test_backpressure();
    long_hold = 1'b1;
    for (int i = 0; i < 10; i++) send_item(decode_item($urandom));
    drain();
  endtask

  task automatic test_stale_tags();
    logic [31:0] b;
    b = 32'h0200_0000;
    send_item(decode_item(b));
    send_item(write_item(b, 24, 16, 24, 16, 384, 0));
    send_item(check_item(2 * (16 * 1024 + 24), 16, 16));
    for (int i = 0; i < RING_DEPTH + 4; i++) send_item(decode_item(32'h0800_0000 + i * 4));
    send_item(check_item(2 * (16 * 1024 + 24), 16, 16));
  endtask

  // mostly well-formed frame: a run of decodes, mostly aligned column writes, a check, sometimes a stop
  task automatic random_frame();
    int cols, bands, c0, r0, nmb, fl;
    logic [31:0] b;
    cols = $urandom_range(1, 3);
    bands = $urandom_range(1, 3);
    c0 = $urandom_range(0, COLS - cols);
    r0 = $urandom_range(0, LINES - bands);
    b = $urandom & ~32'h3;
    nmb = cols * bands + $urandom_range(0, 2);
    for (int i = 0; i < nmb; i++)
      send_item(decode_item(($urandom_range(0, 15) == 0) ? $urandom : b + i * MB_STRIDE));
    for (int c = 0; c < cols; c++) begin
      fl = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 511)
                                        : (r0 * 16 - 16 * $urandom_range(0, r0)) & 511;
      send_item(write_item(b + c * bands * MB_STRIDE, (c0 + c) * CELL_WORDS, r0 * 16,
                           ($urandom_range(0, 15) == 0) ? $urandom_range(1, 48) : 24,
                           bands * 16 + $urandom_range(0, 1) * $urandom_range(0, 20),
                           bands * 384 + $urandom_range(0, 2) * $urandom_range(0, 100),
                           fl));
    end
    send_item(check_item(2 * (r0 * 16 * 1024 + c0 * CELL_WORDS) +
                         (($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : 0),
                         cols * 16 - $urandom_range(0, 15),
                         bands * 16 - $urandom_range(0, 15)));
    if ($urandom_range(0, 3) == 0) send_item(blank_item(OP_STOP));
  endtask

  task automatic test_random(int target);
    while (items_sent < target) begin
      if ($urandom_range(0, 9) < 7) random_frame();
      else send_item(noise_item());
    end
  endtask

  initial begin
    reset_model();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_before_ring_ready();
    test_decode_runs();
    test_tag_and_hit();
    test_field_extremes();
    drain();
    test_backpressure();
    test_stale_tags();
    test_random(items_sent + 500);
    drain();
    idle_on = 1'b0;
    test_random(items_sent + 120);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("sent %0d transactions, checked %0d results, %0d upload hits",
             items_sent, results_seen, hits_seen);
    $display("covered decodes, run wrap, aligned and misaligned writes, checks, stops");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/mpt_pkg.sv
rtl/mpt_ram.sv
rtl/mpt_datapath.sv
rtl/mpt_controller.sv
rtl/macroblock_provenance_tracker.sv
sim/macroblock_provenance_tracker_tb.sv
